// ===== rtl/cpu_load_store_unit_assert.svh =====
// Assertion macros for the load/store unit checks
`ifndef CPU_LOAD_STORE_UNIT_ASSERT_SVH
`define CPU_LOAD_STORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LSU_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("load/store unit check failed");
`define LSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("load/store unit check failed");
`else
`define LSU_ASSERT_IMPLY(label, ante, cons)
`define LSU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/clsu_pkg.sv =====
// Shared types, constants and decode for the load/store unit
package clsu_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] HIGH_PAGE = 16'hFF00;
	localparam logic [2:0] REG_C = 3'd1;
	localparam logic [2:0] REG_A = 3'd6;
	localparam logic [2:0] REG_F = 3'd7;
	localparam logic [2:0] REG_HL_CODE = 3'd6;
	localparam logic [3:0] TGT_PAIR_BASE = 4'd8;
	localparam logic [3:0] TGT_HL = 4'd10;
	localparam logic [3:0] TGT_SP = 4'd11;
	localparam logic [1:0] PAIR_AF = 2'd3;

	typedef enum logic [2:0] {
		ACT_READ   = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_UPDATE = 3'd2,
		ACT_UNSUPP = 3'd3,
		ACT_UNEXP  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_LOAD   = 2'd1,
		PEND_POP_LO = 2'd2,
		PEND_POP_HI = 2'd3
	} pend_t;

	typedef enum logic [4:0] {
		C_BAD, C_LD_RR, C_LD_R_HL, C_LD_HL_R, C_LD_R_N, C_LD_HL_N, C_LD_PAIR_NN,
		C_POP, C_PUSH, C_ST_BC, C_ST_DE, C_LD_A_BC, C_LD_A_DE, C_ST_NN_SP,
		C_ST_HLI, C_ST_HLD, C_LD_A_HLI, C_LD_A_HLD, C_LDH_N_A, C_LDH_A_N,
		C_LDH_C_A, C_LDH_A_C, C_ST_NN_A, C_LD_A_NN, C_LD_HL_SPE, C_LD_SP_HL
	} iclass_t;

	typedef struct packed {
		logic        kind;
		iclass_t     cls;
		logic [7:0]  opcode;
		logic [15:0] imm;
		logic [7:0]  rdata;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] address;
		logic [15:0] data;
		logic [3:0]  target;
		logic        last;
		logic [7:0]  acc;
		logic [15:0] hl;
		logic [15:0] sp;
		logic [3:0]  flags;
	} result_t;

	// register field code 7 is A, which sits at index 6 of the file
	function automatic logic [2:0] reg_index(input logic [2:0] code);
		reg_index = (code == 3'd7) ? REG_A : code;
	endfunction

	function automatic iclass_t classify(input logic [7:0] op);
		iclass_t c;
		c = C_BAD;
		if (op[7:6] == 2'b01) begin
			if (op == 8'h76) c = C_BAD;
			else if (op[2:0] == REG_HL_CODE) c = C_LD_R_HL;
			else if (op[5:3] == REG_HL_CODE) c = C_LD_HL_R;
			else c = C_LD_RR;
		end else if (op[7:6] == 2'b00 && op[2:0] == 3'b110) begin
			c = (op[5:3] == REG_HL_CODE) ? C_LD_HL_N : C_LD_R_N;
		end else if (op[7:6] == 2'b00 && op[3:0] == 4'h1) begin
			c = C_LD_PAIR_NN;
		end else if (op[7:6] == 2'b11 && op[3:0] == 4'h1) begin
			c = C_POP;
		end else if (op[7:6] == 2'b11 && op[3:0] == 4'h5) begin
			c = C_PUSH;
		end else begin
			case (op)
				8'h02: c = C_ST_BC;
				8'h12: c = C_ST_DE;
				8'h0A: c = C_LD_A_BC;
				8'h1A: c = C_LD_A_DE;
				8'h08: c = C_ST_NN_SP;
				8'h22: c = C_ST_HLI;
				8'h32: c = C_ST_HLD;
				8'h2A: c = C_LD_A_HLI;
				8'h3A: c = C_LD_A_HLD;
				8'hE0: c = C_LDH_N_A;
				8'hF0: c = C_LDH_A_N;
				8'hE2: c = C_LDH_C_A;
				8'hF2: c = C_LDH_A_C;
				8'hEA: c = C_ST_NN_A;
				8'hFA: c = C_LD_A_NN;
				8'hF8: c = C_LD_HL_SPE;
				8'hF9: c = C_LD_SP_HL;
				default: c = C_BAD;
			endcase
		end
		classify = c;
	endfunction

endpackage

// ===== rtl/clsu_front.sv =====
// Front end: takes transactions, decodes the opcode class, queues them
module clsu_front #(
	parameter int DEPTH = clsu_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         opcode,
	input  logic [15:0]        immediate,
	input  logic [7:0]         read_data,
	output clsu_pkg::qhead_t   head,
	input  logic               pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	clsu_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, do_pop;
	clsu_pkg::item_t  new_item;

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push = in_valid && !in_stall;
	assign do_pop = pop && (count_q != '0);

	always_comb begin
		new_item.kind = kind;
		new_item.cls = clsu_pkg::classify(opcode);
		new_item.opcode = opcode;
		new_item.imm = immediate;
		new_item.rdata = read_data;
	end

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (!push && do_pop) count_q <= count_q - CNT_W'(1);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item = mem_q[rd_ptr_q];

endmodule

// ===== rtl/clsu_back.sv =====
// Back end: register file, stack pointer, execution and result buffering
module clsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clsu_pkg::qhead_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output clsu_pkg::result_t res
);

	logic [7:0][7:0]    rf_q, nrf;
	logic [15:0]        sp_q, nsp;
	clsu_pkg::pend_t    pend_q, npend;
	logic [2:0]         pend_tgt_q, npend_tgt;
	logic [7:0]         pend_lo_q, npend_lo;

	clsu_pkg::result_t  r0, r1, out_q, sec_q;
	logic               two;
	logic               out_vld_q, sec_vld_q, can_take;

	clsu_pkg::item_t    it;
	logic [15:0]        bc, de, hl, pair_v, imm16, spe;
	logic [2:0]         dst, src;
	logic [1:0]         p;
	logic [7:0]         imm8, a, hi, lo;
	logic [4:0]         half_sum;
	logic [8:0]         byte_sum;

	function automatic clsu_pkg::result_t mk(input clsu_pkg::action_t act,
		input logic [15:0] ad, input logic [15:0] d, input logic [3:0] t);
		clsu_pkg::result_t r;
		r = '0;
		r.action = act;
		r.address = ad;
		r.data = d;
		r.target = t;
		mk = r;
	endfunction

	assign it = head.item;
	assign bc = {rf_q[0], rf_q[1]};
	assign de = {rf_q[2], rf_q[3]};
	assign hl = {rf_q[4], rf_q[5]};
	assign a = rf_q[clsu_pkg::REG_A];
	assign dst = clsu_pkg::reg_index(it.opcode[5:3]);
	assign src = clsu_pkg::reg_index(it.opcode[2:0]);
	assign p = it.opcode[5:4];
	assign imm8 = it.imm[7:0];
	assign imm16 = it.imm;
	assign half_sum = {1'b0, sp_q[3:0]} + {1'b0, imm8[3:0]};
	assign byte_sum = {1'b0, sp_q[7:0]} + {1'b0, imm8};
	assign spe = sp_q + {{8{imm8[7]}}, imm8};

	always_comb begin
		case (p)
			2'd0: pair_v = bc;
			2'd1: pair_v = de;
			2'd2: pair_v = hl;
			default: pair_v = sp_q;
		endcase
		if (p == clsu_pkg::PAIR_AF) begin
			hi = a;
			lo = rf_q[clsu_pkg::REG_F];
		end else begin
			hi = pair_v[15:8];
			lo = pair_v[7:0];
		end
	end

	always_comb begin
		nrf = rf_q;
		nsp = sp_q;
		npend = pend_q;
		npend_tgt = pend_tgt_q;
		npend_lo = pend_lo_q;
		r0 = mk(clsu_pkg::ACT_UNEXP, '0, '0, '0);
		r1 = '0;
		two = 1'b0;
		if (it.kind) begin
			case (pend_q)
				clsu_pkg::PEND_LOAD: begin
					nrf[pend_tgt_q] = it.rdata;
					npend = clsu_pkg::PEND_NONE;
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, {8'h00, it.rdata}, {1'b0, pend_tgt_q});
				end
				clsu_pkg::PEND_POP_LO: begin
					npend_lo = it.rdata;
					npend = clsu_pkg::PEND_POP_HI;
					r0 = mk(clsu_pkg::ACT_READ, sp_q, '0, '0);
					nsp = sp_q + 16'd1;
				end
				clsu_pkg::PEND_POP_HI: begin
					npend = clsu_pkg::PEND_NONE;
					if (pend_tgt_q[1:0] == clsu_pkg::PAIR_AF) begin
						nrf[clsu_pkg::REG_A] = it.rdata;
						nrf[clsu_pkg::REG_F] = {pend_lo_q[7:4], 4'h0};
						r0 = mk(clsu_pkg::ACT_UPDATE, '0, {8'h00, it.rdata},
							{1'b0, clsu_pkg::REG_A});
						r1 = mk(clsu_pkg::ACT_UPDATE, '0, {8'h00, pend_lo_q[7:4], 4'h0},
							{1'b0, clsu_pkg::REG_F});
						two = 1'b1;
					end else begin
						nrf[{pend_tgt_q[1:0], 1'b0}] = it.rdata;
						nrf[{pend_tgt_q[1:0], 1'b1}] = pend_lo_q;
						r0 = mk(clsu_pkg::ACT_UPDATE, '0, {it.rdata, pend_lo_q},
							clsu_pkg::TGT_PAIR_BASE + {2'b00, pend_tgt_q[1:0]});
					end
				end
				default: begin
					npend = clsu_pkg::PEND_NONE;
				end
			endcase
		end else if (pend_q == clsu_pkg::PEND_NONE) begin
			case (it.cls)
				clsu_pkg::C_LD_RR: begin
					nrf[dst] = rf_q[src];
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, {8'h00, rf_q[src]}, {1'b0, dst});
				end
				clsu_pkg::C_LD_R_HL: begin
					npend = clsu_pkg::PEND_LOAD;
					npend_tgt = dst;
					r0 = mk(clsu_pkg::ACT_READ, hl, '0, '0);
				end
				clsu_pkg::C_LD_HL_R: r0 = mk(clsu_pkg::ACT_WRITE, hl, {8'h00, rf_q[src]}, '0);
				clsu_pkg::C_LD_R_N: begin
					nrf[dst] = imm8;
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, {8'h00, imm8}, {1'b0, dst});
				end
				clsu_pkg::C_LD_HL_N: r0 = mk(clsu_pkg::ACT_WRITE, hl, {8'h00, imm8}, '0);
				clsu_pkg::C_LD_PAIR_NN: begin
					if (p == 2'd3) nsp = imm16;
					else begin
						nrf[{p, 1'b0}] = imm16[15:8];
						nrf[{p, 1'b1}] = imm16[7:0];
					end
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, imm16,
						clsu_pkg::TGT_PAIR_BASE + {2'b00, p});
				end
				clsu_pkg::C_POP: begin
					npend = clsu_pkg::PEND_POP_LO;
					npend_tgt = {1'b0, p};
					r0 = mk(clsu_pkg::ACT_READ, sp_q, '0, '0);
					nsp = sp_q + 16'd1;
				end
				clsu_pkg::C_PUSH: begin
					r0 = mk(clsu_pkg::ACT_WRITE, sp_q - 16'd1, {8'h00, hi}, '0);
					r1 = mk(clsu_pkg::ACT_WRITE, sp_q - 16'd2, {8'h00, lo}, '0);
					two = 1'b1;
					nsp = sp_q - 16'd2;
				end
				clsu_pkg::C_ST_BC: r0 = mk(clsu_pkg::ACT_WRITE, bc, {8'h00, a}, '0);
				clsu_pkg::C_ST_DE: r0 = mk(clsu_pkg::ACT_WRITE, de, {8'h00, a}, '0);
				clsu_pkg::C_LD_A_BC, clsu_pkg::C_LD_A_DE, clsu_pkg::C_LD_A_HLI,
				clsu_pkg::C_LD_A_HLD, clsu_pkg::C_LDH_A_N, clsu_pkg::C_LDH_A_C,
				clsu_pkg::C_LD_A_NN: begin
					npend = clsu_pkg::PEND_LOAD;
					npend_tgt = clsu_pkg::REG_A;
					case (it.cls)
						clsu_pkg::C_LD_A_BC: r0 = mk(clsu_pkg::ACT_READ, bc, '0, '0);
						clsu_pkg::C_LD_A_DE: r0 = mk(clsu_pkg::ACT_READ, de, '0, '0);
						clsu_pkg::C_LDH_A_N:
							r0 = mk(clsu_pkg::ACT_READ, clsu_pkg::HIGH_PAGE | {8'h00, imm8},
								'0, '0);
						clsu_pkg::C_LDH_A_C:
							r0 = mk(clsu_pkg::ACT_READ,
								clsu_pkg::HIGH_PAGE | {8'h00, rf_q[clsu_pkg::REG_C]}, '0, '0);
						clsu_pkg::C_LD_A_NN: r0 = mk(clsu_pkg::ACT_READ, imm16, '0, '0);
						default: r0 = mk(clsu_pkg::ACT_READ, hl, '0, '0);
					endcase
					if (it.cls == clsu_pkg::C_LD_A_HLI) {nrf[4], nrf[5]} = hl + 16'd1;
					if (it.cls == clsu_pkg::C_LD_A_HLD) {nrf[4], nrf[5]} = hl - 16'd1;
				end
				clsu_pkg::C_ST_NN_SP: begin
					r0 = mk(clsu_pkg::ACT_WRITE, imm16, {8'h00, sp_q[7:0]}, '0);
					r1 = mk(clsu_pkg::ACT_WRITE, imm16 + 16'd1, {8'h00, sp_q[15:8]}, '0);
					two = 1'b1;
				end
				clsu_pkg::C_ST_HLI: begin
					r0 = mk(clsu_pkg::ACT_WRITE, hl, {8'h00, a}, '0);
					{nrf[4], nrf[5]} = hl + 16'd1;
				end
				clsu_pkg::C_ST_HLD: begin
					r0 = mk(clsu_pkg::ACT_WRITE, hl, {8'h00, a}, '0);
					{nrf[4], nrf[5]} = hl - 16'd1;
				end
				clsu_pkg::C_LDH_N_A:
					r0 = mk(clsu_pkg::ACT_WRITE, clsu_pkg::HIGH_PAGE | {8'h00, imm8},
						{8'h00, a}, '0);
				clsu_pkg::C_LDH_C_A:
					r0 = mk(clsu_pkg::ACT_WRITE,
						clsu_pkg::HIGH_PAGE | {8'h00, rf_q[clsu_pkg::REG_C]}, {8'h00, a}, '0);
				clsu_pkg::C_ST_NN_A: r0 = mk(clsu_pkg::ACT_WRITE, imm16, {8'h00, a}, '0);
				clsu_pkg::C_LD_HL_SPE: begin
					// Z and N clear; H and C from the unsigned low-byte add
					nrf[clsu_pkg::REG_F] = {2'b00, half_sum[4], byte_sum[8], 4'h0};
					{nrf[4], nrf[5]} = spe;
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, spe, clsu_pkg::TGT_HL);
				end
				clsu_pkg::C_LD_SP_HL: begin
					nsp = hl;
					r0 = mk(clsu_pkg::ACT_UPDATE, '0, hl, clsu_pkg::TGT_SP);
				end
				default: r0 = mk(clsu_pkg::ACT_UNSUPP, '0, '0, '0);
			endcase
		end
		r0.last = !two;
		r1.last = 1'b1;
		r0.acc = nrf[clsu_pkg::REG_A];
		r1.acc = nrf[clsu_pkg::REG_A];
		r0.hl = {nrf[4], nrf[5]};
		r1.hl = {nrf[4], nrf[5]};
		r0.sp = nsp;
		r1.sp = nsp;
		r0.flags = nrf[clsu_pkg::REG_F][7:4];
		r1.flags = nrf[clsu_pkg::REG_F][7:4];
	end

	// a new transaction starts only when both results fit in the output stage
	assign can_take = (!out_vld_q || !out_stall) && !sec_vld_q;
	assign pop = head.valid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= '0;
			sp_q <= '0;
			pend_q <= clsu_pkg::PEND_NONE;
			pend_tgt_q <= '0;
			pend_lo_q <= '0;
			out_vld_q <= 1'b0;
			sec_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				rf_q <= nrf;
				sp_q <= nsp;
				pend_q <= npend;
				pend_tgt_q <= npend_tgt;
				pend_lo_q <= npend_lo;
				out_vld_q <= 1'b1;
				sec_vld_q <= two;
			end else if (sec_vld_q && (!out_vld_q || !out_stall)) begin
				out_vld_q <= 1'b1;
				sec_vld_q <= 1'b0;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= r0;
			if (two) sec_q <= r1;
		end else if (sec_vld_q && (!out_vld_q || !out_stall)) begin
			out_q <= sec_q;
		end
	end

	assign out_valid = out_vld_q;
	assign res = out_q;

endmodule

// ===== rtl/cpu_load_store_unit.sv =====
// Top level of the load/store unit: front decode queue and back execution
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in       | in_valid / in_stall | kind, opcode, immediate, read_data
//  out      | out_valid/out_stall | action, address, data, target, last,
//           |                     | acc_value, hl_value, sp_value, flag_bits
//
// One transaction per cycle when it makes one result and out_stall is low; one that
// makes two (push, pop AF, store SP) holds off the next one until its second result
// has moved into the output register, which sets this pace. Items reach it through the decode queue.
// Reset clears register file, stack pointer and pending read state.
// out_stall backs up the queue; in_stall rises once the queue is full.
`include "cpu_load_store_unit_assert.svh"
module cpu_load_store_unit #(
	parameter int QUEUE_DEPTH = clsu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  opcode,
	input  logic [15:0] immediate,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [15:0] address,
	output logic [15:0] data,
	output logic [3:0]  target,
	output logic        last,
	output logic [7:0]  acc_value,
	output logic [15:0] hl_value,
	output logic [15:0] sp_value,
	output logic [3:0]  flag_bits
);

	clsu_pkg::qhead_t  head;
	clsu_pkg::result_t res;
	logic              pop;
	logic              err_out;

	clsu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.opcode(opcode),
		.immediate(immediate),
		.read_data(read_data),
		.head(head),
		.pop(pop)
	);

	clsu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res)
	);

	assign action = res.action;
	assign address = res.address;
	assign data = res.data;
	assign target = res.target;
	assign last = res.last;
	assign acc_value = res.acc;
	assign hl_value = res.hl;
	assign sp_value = res.sp;
	assign flag_bits = res.flags;

	assign err_out = out_valid &&
		(action == clsu_pkg::ACT_UNSUPP || action == clsu_pkg::ACT_UNEXP);

	`LSU_ASSERT_IMPLY(a_read_single, out_valid && action == clsu_pkg::ACT_READ, last)
	`LSU_ASSERT_IMPLY(a_error_single, err_out, last && address == 16'h0000 && data == 16'h0000)
	`LSU_ASSERT_IMPLY(a_target_only_update, out_valid && action != clsu_pkg::ACT_UPDATE, target == 4'd0)
	`LSU_ASSERT_NEXT(a_first_holds_pair, out_valid && !last && out_stall, out_valid && !last)

endmodule
